/* src/psat_pkg.sv */
// psat_pkg: shared constants, operation codes and control/status types
// for the polygon separating-axis overlap block
// no dependencies
package psat_pkg;

   localparam int MAX_VERTS = 16;
   localparam int IDX_W = $clog2(MAX_VERTS);
   localparam int CNT_W = $clog2(MAX_VERTS + 1);
   localparam int STEP_W = 6;
   localparam int SQRT_STEPS = 32;
   localparam int DIV_STEPS = 31;
   localparam logic [30:0] DEPTH_SAT = 31'h7fffffff;

   localparam logic [1:0] REQ_VERT_A = 2'd0;
   localparam logic [1:0] REQ_VERT_B = 2'd1;
   localparam logic [1:0] REQ_TEST = 2'd2;

   localparam int OP_W = 5;
   localparam logic [OP_W-1:0] OP_NONE = 5'd0;
   localparam logic [OP_W-1:0] OP_LOAD_A = 5'd1;
   localparam logic [OP_W-1:0] OP_LOAD_B = 5'd2;
   localparam logic [OP_W-1:0] OP_TEST_INIT = 5'd3;
   localparam logic [OP_W-1:0] OP_EDGE0 = 5'd4;
   localparam logic [OP_W-1:0] OP_EDGE1 = 5'd5;
   localparam logic [OP_W-1:0] OP_NORM = 5'd6;
   localparam logic [OP_W-1:0] OP_SQ = 5'd7;
   localparam logic [OP_W-1:0] OP_SQ_SUM = 5'd8;
   localparam logic [OP_W-1:0] OP_SQRT = 5'd9;
   localparam logic [OP_W-1:0] OP_DIV = 5'd10;
   localparam logic [OP_W-1:0] OP_NSET = 5'd11;
   localparam logic [OP_W-1:0] OP_PMUL = 5'd12;
   localparam logic [OP_W-1:0] OP_PACC_A = 5'd13;
   localparam logic [OP_W-1:0] OP_PACC_B = 5'd14;
   localparam logic [OP_W-1:0] OP_OFFMUL = 5'd15;
   localparam logic [OP_W-1:0] OP_OFFACC = 5'd16;

   typedef struct packed {
      logic [OP_W-1:0]  op;
      logic             rd_a_en;
      logic             rd_b_en;
      logic             src_b;
      logic             first;
      logic [IDX_W-1:0] addr;
      logic             rsp_load;
   } dp_cmd_type;

   typedef struct packed {
      logic zero_edge;
      logic norm_hi;
      logic norm_lo;
      logic hit;
   } dp_stat_type;

endpackage

/* src/psat_dp.sv */
// psat_dp: datapath with vertex stores, shared multipliers, square root,
// normal divider, projection ranges and result payload registers
// depends on psat_pkg
module psat_dp (
   input  logic                    clock,
   input  psat_pkg::dp_cmd_type    cmd,
   input  logic signed [31:0]      req_vert_x,
   input  logic signed [31:0]      req_vert_y,
   input  logic signed [31:0]      req_pos_a_x,
   input  logic signed [31:0]      req_pos_a_y,
   input  logic signed [31:0]      req_pos_b_x,
   input  logic signed [31:0]      req_pos_b_y,
   output psat_pkg::dp_stat_type   stat,
   output logic                    rsp_collides,
   output logic [30:0]             rsp_depth
);

   logic [63:0] mem_a [psat_pkg::MAX_VERTS];
   logic [63:0] mem_b [psat_pkg::MAX_VERTS];
   logic [63:0] rd_a_ff, rd_b_ff;

   logic signed [32:0] offx_ff, offx_in, offy_ff, offy_in;
   logic signed [31:0] vi_x_ff, vi_x_in, vi_y_ff, vi_y_in;
   logic dx_neg_ff, dx_neg_in, dy_neg_ff, dy_neg_in, zero_ff, zero_in;
   logic [32:0] ax_ff, ax_in, ay_ff, ay_in;
   logic signed [64:0] prod_x_ff, prod_y_ff;
   logic [63:0] s_ff, s_in, res_ff, res_in, bit_ff, bit_in;
   logic [31:0] remx_ff, remx_in, remy_ff, remy_in;
   logic [30:0] qx_ff, qx_in, qy_ff, qy_in;
   logic signed [31:0] nx_ff, nx_in, ny_ff, ny_in;
   logic signed [35:0] lo_a_ff, lo_a_in, hi_a_ff, hi_a_in;
   logic signed [35:0] lo_b_ff, lo_b_in, hi_b_ff, hi_b_in;
   logic [30:0] best_ff, best_in;
   logic hit_ff, hit_in;
   logic rsp_collides_ff, rsp_collides_in;
   logic [30:0] rsp_depth_ff, rsp_depth_in;

   logic signed [31:0] ma_x, ma_y;
   logic signed [32:0] mb_x, mb_y;
   logic [63:0] vsel;
   logic signed [31:0] vx, vy;
   logic [32:0] mag;
   logic signed [32:0] dx, dy;
   logic [63:0] sq_t;
   logic [32:0] tx, ty, len33;
   logic [30:0] qxb, qyb;
   logic signed [65:0] psum;
   logic signed [35:0] proj;
   logic signed [36:0] mina2, maxa2;
   logic signed [37:0] dd, dabs;
   logic gap;

   always_ff @(posedge clock) begin
      if (cmd.op == psat_pkg::OP_LOAD_A) begin
         mem_a[cmd.addr] <= {req_vert_x, req_vert_y};
      end
      if (cmd.op == psat_pkg::OP_LOAD_B) begin
         mem_b[cmd.addr] <= {req_vert_x, req_vert_y};
      end
      if (cmd.rd_a_en) begin
         rd_a_ff <= mem_a[cmd.addr];
      end
      if (cmd.rd_b_en) begin
         rd_b_ff <= mem_b[cmd.addr];
      end
   end

   // operand selection for the two shared multipliers
   always_comb begin
      vsel = cmd.src_b ? rd_b_ff : rd_a_ff;
      vx = $signed(vsel[63:32]);
      vy = $signed(vsel[31:0]);
      ma_x = '0;
      ma_y = '0;
      mb_x = '0;
      mb_y = '0;
      case (cmd.op)
         psat_pkg::OP_SQ: begin
            ma_x = $signed({1'b0, ax_ff[30:0]});
            mb_x = $signed({2'b00, ax_ff[30:0]});
            ma_y = $signed({1'b0, ay_ff[30:0]});
            mb_y = $signed({2'b00, ay_ff[30:0]});
         end
         psat_pkg::OP_PMUL: begin
            ma_x = nx_ff;
            ma_y = ny_ff;
            mb_x = {vx[31], vx};
            mb_y = {vy[31], vy};
         end
         psat_pkg::OP_OFFMUL: begin
            ma_x = nx_ff;
            ma_y = ny_ff;
            mb_x = offx_ff;
            mb_y = offy_ff;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      prod_x_ff <= 65'(ma_x) * 65'(mb_x);
      prod_y_ff <= 65'(ma_y) * 65'(mb_y);
   end

   always_comb begin
      offx_in = offx_ff;
      offy_in = offy_ff;
      vi_x_in = vi_x_ff;
      vi_y_in = vi_y_ff;
      dx_neg_in = dx_neg_ff;
      dy_neg_in = dy_neg_ff;
      zero_in = zero_ff;
      ax_in = ax_ff;
      ay_in = ay_ff;
      s_in = s_ff;
      res_in = res_ff;
      bit_in = bit_ff;
      remx_in = remx_ff;
      remy_in = remy_ff;
      qx_in = qx_ff;
      qy_in = qy_ff;
      nx_in = nx_ff;
      ny_in = ny_ff;
      lo_a_in = lo_a_ff;
      hi_a_in = hi_a_ff;
      lo_b_in = lo_b_ff;
      hi_b_in = hi_b_ff;
      best_in = best_ff;
      hit_in = hit_ff;
      rsp_collides_in = rsp_collides_ff;
      rsp_depth_in = rsp_depth_ff;

      mag = (ax_ff > ay_ff) ? ax_ff : ay_ff;
      dx = $signed({rd_a_ff[63], rd_a_ff[63:32]}) - $signed({vi_x_ff[31], vi_x_ff});
      dy = $signed({rd_a_ff[31], rd_a_ff[31:0]}) - $signed({vi_y_ff[31], vi_y_ff});
      sq_t = res_ff + bit_ff;
      len33 = {1'b0, res_ff[31:0]};
      tx = cmd.first ? {1'b0, ay_ff[31:1], ay_ff[0]} : {remx_ff, 1'b0};
      ty = cmd.first ? {1'b0, ax_ff[31:1], ax_ff[0]} : {remy_ff, 1'b0};
      qxb = cmd.first ? '0 : qx_ff;
      qyb = cmd.first ? '0 : qy_ff;
      psum = {prod_x_ff[64], prod_x_ff} + {prod_y_ff[64], prod_y_ff};
      proj = psum[65:30];
      mina2 = {lo_a_ff[35], lo_a_ff} + {proj[35], proj};
      maxa2 = {hi_a_ff[35], hi_a_ff} + {proj[35], proj};
      gap = (mina2 > $signed({hi_b_ff[35], hi_b_ff}))
            || ($signed({lo_b_ff[35], lo_b_ff}) > maxa2);
      dd = {hi_b_ff[35], hi_b_ff[35], hi_b_ff} - {mina2[36], mina2};
      dabs = dd[37] ? -dd : dd;

      case (cmd.op)
         psat_pkg::OP_TEST_INIT: begin
            offx_in = {req_pos_a_x[31], req_pos_a_x} - {req_pos_b_x[31], req_pos_b_x};
            offy_in = {req_pos_a_y[31], req_pos_a_y} - {req_pos_b_y[31], req_pos_b_y};
            best_in = psat_pkg::DEPTH_SAT;
            hit_in = 1'b1;
         end
         psat_pkg::OP_EDGE0: begin
            vi_x_in = $signed(rd_a_ff[63:32]);
            vi_y_in = $signed(rd_a_ff[31:0]);
         end
         psat_pkg::OP_EDGE1: begin
            dx_neg_in = dx[32];
            dy_neg_in = dy[32];
            ax_in = dx[32] ? 33'(-dx) : 33'(dx);
            ay_in = dy[32] ? 33'(-dy) : 33'(dy);
            zero_in = (dx == '0) && (dy == '0);
         end
         psat_pkg::OP_NORM: begin
            if (mag[32] || mag[31]) begin
               ax_in = ax_ff >> 1;
               ay_in = ay_ff >> 1;
            end else begin
               ax_in = ax_ff << 1;
               ay_in = ay_ff << 1;
            end
         end
         psat_pkg::OP_SQ_SUM: begin
            s_in = {1'b0, prod_x_ff[62:0]} + {1'b0, prod_y_ff[62:0]};
            res_in = '0;
            bit_in = 64'd1 << 62;
         end
         psat_pkg::OP_SQRT: begin
            if (s_ff >= sq_t) begin
               s_in = s_ff - sq_t;
               res_in = (res_ff >> 1) + bit_ff;
            end else begin
               res_in = res_ff >> 1;
            end
            bit_in = bit_ff >> 2;
         end
         psat_pkg::OP_DIV: begin
            if (tx >= len33) begin
               remx_in = 32'(tx - len33);
               qx_in = {qxb[29:0], 1'b1};
            end else begin
               remx_in = tx[31:0];
               qx_in = {qxb[29:0], 1'b0};
            end
            if (ty >= len33) begin
               remy_in = 32'(ty - len33);
               qy_in = {qyb[29:0], 1'b1};
            end else begin
               remy_in = ty[31:0];
               qy_in = {qyb[29:0], 1'b0};
            end
         end
         psat_pkg::OP_NSET: begin
            if (zero_ff) begin
               nx_in = '0;
               ny_in = '0;
            end else begin
               nx_in = dy_neg_ff ? $signed({1'b0, qx_ff}) : -$signed({1'b0, qx_ff});
               ny_in = dx_neg_ff ? -$signed({1'b0, qy_ff}) : $signed({1'b0, qy_ff});
            end
            lo_a_in = '0;
            hi_a_in = '0;
            lo_b_in = '0;
            hi_b_in = '0;
         end
         psat_pkg::OP_PACC_A: begin
            if (cmd.first || proj < lo_a_ff) lo_a_in = proj;
            if (cmd.first || proj > hi_a_ff) hi_a_in = proj;
         end
         psat_pkg::OP_PACC_B: begin
            if (cmd.first || proj < lo_b_ff) lo_b_in = proj;
            if (cmd.first || proj > hi_b_ff) hi_b_in = proj;
         end
         psat_pkg::OP_OFFACC: begin
            if (gap) begin
               hit_in = 1'b0;
            end else if (dabs < $signed({7'b0, best_ff})) begin
               best_in = dabs[30:0];
            end
         end
         default: begin
         end
      endcase

      if (cmd.rsp_load) begin
         rsp_collides_in = hit_ff;
         rsp_depth_in = hit_ff ? best_ff : '0;
      end
   end

   always_ff @(posedge clock) begin
      offx_ff <= offx_in;
      offy_ff <= offy_in;
      vi_x_ff <= vi_x_in;
      vi_y_ff <= vi_y_in;
      dx_neg_ff <= dx_neg_in;
      dy_neg_ff <= dy_neg_in;
      zero_ff <= zero_in;
      ax_ff <= ax_in;
      ay_ff <= ay_in;
      s_ff <= s_in;
      res_ff <= res_in;
      bit_ff <= bit_in;
      remx_ff <= remx_in;
      remy_ff <= remy_in;
      qx_ff <= qx_in;
      qy_ff <= qy_in;
      nx_ff <= nx_in;
      ny_ff <= ny_in;
      lo_a_ff <= lo_a_in;
      hi_a_ff <= hi_a_in;
      lo_b_ff <= lo_b_in;
      hi_b_ff <= hi_b_in;
      best_ff <= best_in;
      hit_ff <= hit_in;
      rsp_collides_ff <= rsp_collides_in;
      rsp_depth_ff <= rsp_depth_in;
   end

   assign stat.zero_edge = zero_ff;
   assign stat.norm_hi = mag[32] || mag[31];
   assign stat.norm_lo = (mag[32:30] == 3'b000);
   assign stat.hit = hit_ff;
   assign rsp_collides = rsp_collides_ff;
   assign rsp_depth = rsp_depth_ff;

endmodule

/* src/psat_ctrl.sv */
// psat_ctrl: sequencer for vertex loads and the per-axis test, vertex
// counts, overflow flag and result beat handshake
// depends on psat_pkg
module psat_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [1:0]            req_type,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic                  rsp_store_overflow,
   output psat_pkg::dp_cmd_type  cmd,
   input  psat_pkg::dp_stat_type stat
);

   localparam logic [4:0] S_IDLE    = 5'd0;
   localparam logic [4:0] S_RDI     = 5'd1;
   localparam logic [4:0] S_RDJ     = 5'd2;
   localparam logic [4:0] S_EDGE    = 5'd3;
   localparam logic [4:0] S_CHK     = 5'd4;
   localparam logic [4:0] S_NORM    = 5'd5;
   localparam logic [4:0] S_SQ      = 5'd6;
   localparam logic [4:0] S_SUM     = 5'd7;
   localparam logic [4:0] S_SQRT    = 5'd8;
   localparam logic [4:0] S_DIV     = 5'd9;
   localparam logic [4:0] S_NSET    = 5'd10;
   localparam logic [4:0] S_PA_RD   = 5'd11;
   localparam logic [4:0] S_PA_MUL  = 5'd12;
   localparam logic [4:0] S_PA_ACC  = 5'd13;
   localparam logic [4:0] S_PB_RD   = 5'd14;
   localparam logic [4:0] S_PB_MUL  = 5'd15;
   localparam logic [4:0] S_PB_ACC  = 5'd16;
   localparam logic [4:0] S_OFF_MUL = 5'd17;
   localparam logic [4:0] S_OFF_ACC = 5'd18;
   localparam logic [4:0] S_AXIS    = 5'd19;
   localparam logic [4:0] S_DONE    = 5'd20;

   logic [4:0] state_ff, state_in;
   logic [psat_pkg::CNT_W-1:0] cnt_a_ff, cnt_a_in, cnt_b_ff, cnt_b_in;
   logic [psat_pkg::CNT_W-1:0] vidx_ff, vidx_in, edge_nx;
   logic [psat_pkg::IDX_W-1:0] edge_ff, edge_in;
   logic [psat_pkg::STEP_W-1:0] step_ff, step_in;
   logic ovf_ff, ovf_in;
   logic rsp_valid_ff, rsp_valid_in, rsp_ovf_ff, rsp_ovf_in;
   logic accept;

   assign req_stall = (state_ff != S_IDLE);
   assign accept = req_valid && !req_stall;
   assign edge_nx = {1'b0, edge_ff} + 1'b1;

   always_comb begin
      state_in = state_ff;
      cnt_a_in = cnt_a_ff;
      cnt_b_in = cnt_b_ff;
      vidx_in = vidx_ff;
      edge_in = edge_ff;
      step_in = step_ff;
      ovf_in = ovf_ff;
      rsp_ovf_in = rsp_ovf_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      cmd = '0;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               case (req_type)
                  psat_pkg::REQ_VERT_A: begin
                     if (cnt_a_ff < psat_pkg::CNT_W'(psat_pkg::MAX_VERTS)) begin
                        cmd.op = psat_pkg::OP_LOAD_A;
                        cmd.addr = cnt_a_ff[psat_pkg::IDX_W-1:0];
                        cnt_a_in = cnt_a_ff + 1'b1;
                     end else begin
                        ovf_in = 1'b1;
                     end
                  end
                  psat_pkg::REQ_VERT_B: begin
                     if (cnt_b_ff < psat_pkg::CNT_W'(psat_pkg::MAX_VERTS)) begin
                        cmd.op = psat_pkg::OP_LOAD_B;
                        cmd.addr = cnt_b_ff[psat_pkg::IDX_W-1:0];
                        cnt_b_in = cnt_b_ff + 1'b1;
                     end else begin
                        ovf_in = 1'b1;
                     end
                  end
                  psat_pkg::REQ_TEST: begin
                     cmd.op = psat_pkg::OP_TEST_INIT;
                     edge_in = '0;
                     state_in = (cnt_a_ff == '0) ? S_DONE : S_RDI;
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_RDI: begin
            cmd.rd_a_en = 1'b1;
            cmd.addr = edge_ff;
            state_in = S_RDJ;
         end
         S_RDJ: begin
            cmd.op = psat_pkg::OP_EDGE0;
            cmd.rd_a_en = 1'b1;
            cmd.addr = (edge_nx < cnt_a_ff) ? edge_nx[psat_pkg::IDX_W-1:0] : '0;
            state_in = S_EDGE;
         end
         S_EDGE: begin
            cmd.op = psat_pkg::OP_EDGE1;
            state_in = S_CHK;
         end
         S_CHK: begin
            state_in = stat.zero_edge ? S_NSET : S_NORM;
         end
         S_NORM: begin
            if (stat.norm_hi || stat.norm_lo) begin
               cmd.op = psat_pkg::OP_NORM;
            end else begin
               state_in = S_SQ;
            end
         end
         S_SQ: begin
            cmd.op = psat_pkg::OP_SQ;
            state_in = S_SUM;
         end
         S_SUM: begin
            cmd.op = psat_pkg::OP_SQ_SUM;
            step_in = '0;
            state_in = S_SQRT;
         end
         S_SQRT: begin
            cmd.op = psat_pkg::OP_SQRT;
            step_in = step_ff + 1'b1;
            if (step_ff == psat_pkg::STEP_W'(psat_pkg::SQRT_STEPS - 1)) begin
               step_in = '0;
               state_in = S_DIV;
            end
         end
         S_DIV: begin
            cmd.op = psat_pkg::OP_DIV;
            cmd.first = (step_ff == '0);
            step_in = step_ff + 1'b1;
            if (step_ff == psat_pkg::STEP_W'(psat_pkg::DIV_STEPS - 1)) begin
               state_in = S_NSET;
            end
         end
         S_NSET: begin
            cmd.op = psat_pkg::OP_NSET;
            vidx_in = '0;
            state_in = S_PA_RD;
         end
         S_PA_RD: begin
            cmd.rd_a_en = 1'b1;
            cmd.addr = vidx_ff[psat_pkg::IDX_W-1:0];
            state_in = S_PA_MUL;
         end
         S_PA_MUL: begin
            cmd.op = psat_pkg::OP_PMUL;
            state_in = S_PA_ACC;
         end
         S_PA_ACC: begin
            cmd.op = psat_pkg::OP_PACC_A;
            cmd.first = (vidx_ff == '0);
            vidx_in = vidx_ff + 1'b1;
            if (vidx_in == cnt_a_ff) begin
               vidx_in = '0;
               state_in = (cnt_b_ff == '0) ? S_OFF_MUL : S_PB_RD;
            end else begin
               state_in = S_PA_RD;
            end
         end
         S_PB_RD: begin
            cmd.rd_b_en = 1'b1;
            cmd.addr = vidx_ff[psat_pkg::IDX_W-1:0];
            state_in = S_PB_MUL;
         end
         S_PB_MUL: begin
            cmd.op = psat_pkg::OP_PMUL;
            cmd.src_b = 1'b1;
            state_in = S_PB_ACC;
         end
         S_PB_ACC: begin
            cmd.op = psat_pkg::OP_PACC_B;
            cmd.first = (vidx_ff == '0);
            vidx_in = vidx_ff + 1'b1;
            state_in = (vidx_in == cnt_b_ff) ? S_OFF_MUL : S_PB_RD;
         end
         S_OFF_MUL: begin
            cmd.op = psat_pkg::OP_OFFMUL;
            state_in = S_OFF_ACC;
         end
         S_OFF_ACC: begin
            cmd.op = psat_pkg::OP_OFFACC;
            state_in = S_AXIS;
         end
         S_AXIS: begin
            if (!stat.hit || edge_nx == cnt_a_ff) begin
               state_in = S_DONE;
            end else begin
               edge_in = edge_nx[psat_pkg::IDX_W-1:0];
               state_in = S_RDI;
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               cmd.rsp_load = 1'b1;
               rsp_valid_in = 1'b1;
               rsp_ovf_in = ovf_ff;
               cnt_a_in = '0;
               cnt_b_in = '0;
               ovf_in = 1'b0;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         cnt_a_ff <= '0;
         cnt_b_ff <= '0;
         ovf_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_a_ff <= cnt_a_in;
         cnt_b_ff <= cnt_b_in;
         ovf_ff <= ovf_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      vidx_ff <= vidx_in;
      edge_ff <= edge_in;
      step_ff <= step_in;
      rsp_ovf_ff <= rsp_ovf_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_store_overflow = rsp_ovf_ff;

endmodule

/* src/polygon_sat_overlap_test.sv */
// polygon_sat_overlap_test: top level, 2D separating-axis overlap test
// depends on psat_pkg, psat_ctrl, psat_dp
//
// usage
//   req channel: each beat is a vertex of polygon A (req_type 0), a vertex
//   of polygon B (req_type 1) or a test (req_type 2) with both positions.
//   up to 16 vertices per polygon are kept; extra ones are dropped and
//   flagged in rsp_store_overflow of the next test. other types are ignored
//   rsp channel: one beat per test with collides, depth (unsigned Q15.16)
//   and the overflow flag; the test then empties both vertex stores
//   a vertex beat never stalls the req channel. a test holds req_stall
//   while, per edge of A until a separating axis is found, it reads the
//   edge, normalizes it, squares and sums, takes the root, divides for the
//   unit normal (a zero-length edge skips to a zero normal), then projects
//   A, B and the offset; the result beat follows the last axis. the shared
//   multiply pair, root unit and divider are stepped by the sequencer
//   req_stall is high while a test runs; the result register holds a beat
//   while rsp_stall is high and a finished test waits for it to drain
//   reset (synchronous) empties both stores and drops any pending beat
module polygon_sat_overlap_test (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [1:0]         req_type,
   input  logic signed [31:0] req_vert_x,
   input  logic signed [31:0] req_vert_y,
   input  logic signed [31:0] req_pos_a_x,
   input  logic signed [31:0] req_pos_a_y,
   input  logic signed [31:0] req_pos_b_x,
   input  logic signed [31:0] req_pos_b_y,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic               rsp_collides,
   output logic [30:0]        rsp_depth,
   output logic               rsp_store_overflow
);

   psat_pkg::dp_cmd_type  cmd;
   psat_pkg::dp_stat_type stat;

   psat_ctrl u_ctrl (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_type           (req_type),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_store_overflow (rsp_store_overflow),
      .cmd                (cmd),
      .stat               (stat)
   );

   psat_dp u_dp (
      .clock        (clock),
      .cmd          (cmd),
      .req_vert_x   (req_vert_x),
      .req_vert_y   (req_vert_y),
      .req_pos_a_x  (req_pos_a_x),
      .req_pos_a_y  (req_pos_a_y),
      .req_pos_b_x  (req_pos_b_x),
      .req_pos_b_y  (req_pos_b_y),
      .stat         (stat),
      .rsp_collides (rsp_collides),
      .rsp_depth    (rsp_depth)
   );

   a_test_busy: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall && req_type == psat_pkg::REQ_TEST) |=> req_stall)
      else $error("test beat accepted without going busy");

   a_load_no_rsp: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall && req_type != psat_pkg::REQ_TEST) |=> !$rose(rsp_valid))
      else $error("result beat raised by a non-test beat");

   a_depth_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_collides) |-> (rsp_depth == '0))
      else $error("separate result with nonzero depth");

endmodule
